/* src/color_sensor_calibrator_defines.svh */
// assertion macros of the color sensor calibrator rtl, used by the controller
`ifndef COLOR_SENSOR_CALIBRATOR_DEFINES_SVH
`define COLOR_SENSOR_CALIBRATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CSC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("csc assertion failed");

// next-cycle implication, checked outside reset
`define CSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("csc assertion failed");

`endif

/* src/csc_pkg.sv */
// shared types and constants of the color sensor calibrator
package csc_pkg;

	localparam int WARMUP_COUNT_DEF = 8;

	localparam logic [11:0] WHITE_FACTOR_RST = 12'd1792;
	localparam logic [7:0]  BLACK_FACTOR_RST = 8'd77;

	localparam logic [15:0] SAT_LEVEL = 16'hFFFF;

	localparam logic signed [17:0] LUX_R_COEF = -18'sd21277;
	localparam logic signed [17:0] LUX_G_COEF = 18'sd103440;
	localparam logic signed [17:0] LUX_B_COEF = -18'sd47966;

	localparam logic [2:0] STATUS_WARM_TAKEN = 3'd0;
	localparam logic [2:0] STATUS_WARM_SAT   = 3'd1;
	localparam logic [2:0] STATUS_WARM_DARK  = 3'd2;
	localparam logic [2:0] STATUS_COLOR      = 3'd3;
	localparam logic [2:0] STATUS_SAT        = 3'd4;
	localparam logic [2:0] STATUS_TOO_DARK   = 3'd5;

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic       load;
		logic       prod1;
		logic       prod2;
		logic       check;
		logic       lux_en;
		logic       lux_store;
		logic       mul1;
		logic       mul2;
		logic       mul3;
		logic       div_init;
		logic       div_step;
		logic       store;
		logic       publish;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic warm;
		logic sat;
		logic dark;
		logic white;
		logic out_busy;
	} sts_t;

endpackage

/* src/csc_datapath.sv */
// datapath of the color sensor calibrator: sums, products, lux and divider
module csc_datapath import csc_pkg::*; #(
	parameter int WARMUP_COUNT = WARMUP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] clear_raw,
	input  logic [15:0] red_raw,
	input  logic [15:0] green_raw,
	input  logic [15:0] blue_raw,
	input  logic [11:0] white_factor_q8,
	input  logic [7:0]  black_factor_q8,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [2:0]  status,
	output logic        calibrated,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [20:0] lux_q4
);

	localparam int NW   = $clog2(WARMUP_COUNT + 1);
	localparam int AW   = 24 + NW;
	localparam int TW   = 25 + NW;
	localparam int PBW  = 30;
	localparam int PWW  = 34;
	localparam int KW   = (TW > PWW) ? TW + 1 : PWW + 1;
	localparam int XNW  = 16 + AW;
	localparam int NUMW = XNW + 8;
	localparam int CSW  = 38;
	localparam int DENW = 50;
	localparam int CMPW = (NUMW > DENW + 8) ? NUMW : DENW + 8;

	logic [NW-1:0] n_c;
	assign n_c = NW'(WARMUP_COUNT);

	logic [15:0] c_q, r_q, g_q, b_q;
	logic [6:0]  cnt_q;
	logic [21:0] sumc_q, sumr_q, sumg_q, sumb_q;
	logic [PBW-1:0] pb_q;
	logic [PWW-1:0] pw_q;
	logic [TW-1:0]  thr_q;
	logic [AW-1:0]  a_q, num_q;
	logic [11:0]    span_q;
	logic signed [35:0] acc_q;
	logic [XNW-1:0]  xn_q;
	logic [CSW-1:0]  cs_q;
	logic [NUMW-1:0] numer_q;
	logic [DENW-1:0] den_q;
	logic [CMPW-1:0] rem_q, d_q;
	logic [7:0]      q_q;
	logic            sat_q, zero_q;
	logic [2:0]      res_status_q;
	logic            res_cal_q;
	logic [7:0]      res_r_q, res_g_q, res_b_q;
	logic [20:0]     res_lux_q;
	logic            out_valid_q;

	logic [16:0]      cp1;
	logic [16+NW:0]   thr_m;
	logic [15+NW:0]   a_m;
	logic [15:0]      x_sel;
	logic [21:0]      sx_sel;
	logic signed [17:0] coef_sel;
	logic signed [34:0] lux_term;
	logic [7:0]       ch_val;
	logic [6:0]       cnt_inc;

	assign cp1   = {1'b0, c_q} + 17'd1;
	assign thr_m = (17 + NW)'(cp1) * (17 + NW)'(n_c);
	assign a_m   = (16 + NW)'(c_q) * (16 + NW)'(n_c);
	assign cnt_inc = cnt_q + 7'd1;

	always_comb begin
		unique case (cmd.idx)
			CH_RED: begin
				x_sel = r_q; sx_sel = sumr_q; coef_sel = LUX_R_COEF;
			end
			CH_GREEN: begin
				x_sel = g_q; sx_sel = sumg_q; coef_sel = LUX_G_COEF;
			end
			CH_BLUE: begin
				x_sel = b_q; sx_sel = sumb_q; coef_sel = LUX_B_COEF;
			end
			default: begin
				x_sel = '0; sx_sel = '0; coef_sel = '0;
			end
		endcase
	end

	assign lux_term = coef_sel * $signed({1'b0, x_sel});
	assign ch_val   = zero_q ? 8'd0 : (sat_q ? 8'd255 : q_q);

	assign sts.warm     = cnt_q < 7'(WARMUP_COUNT);
	assign sts.sat      = c_q == SAT_LEVEL;
	assign sts.dark     = KW'(thr_q) <= KW'(pb_q);
	assign sts.white    = KW'(a_q) >= KW'(pw_q);
	assign sts.out_busy = out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sumc_q <= '0;
			sumr_q <= '0;
			sumg_q <= '0;
			sumb_q <= '0;
		end else if (cmd.check && sts.warm && !sts.sat && c_q != 16'd0) begin
			cnt_q  <= cnt_inc;
			sumc_q <= sumc_q + 22'(c_q);
			sumr_q <= sumr_q + 22'(r_q);
			sumg_q <= sumg_q + 22'(g_q);
			sumb_q <= sumb_q + 22'(b_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			c_q <= clear_raw;
			r_q <= red_raw;
			g_q <= green_raw;
			b_q <= blue_raw;
		end
		if (cmd.prod1) begin
			pb_q  <= PBW'(sumc_q) * PBW'(black_factor_q8);
			thr_q <= {thr_m, 8'd0};
			a_q   <= {a_m, 8'd0};
		end
		if (cmd.prod2) begin
			pw_q <= PWW'(sumc_q) * PWW'(white_factor_q8);
		end
		if (cmd.check) begin
			num_q  <= (KW'(a_q) > KW'(pb_q)) ? AW'(KW'(a_q) - KW'(pb_q)) : '0;
			span_q <= (white_factor_q8 > {4'd0, black_factor_q8}) ?
				white_factor_q8 - {4'd0, black_factor_q8} : 12'd0;
			res_r_q   <= '0;
			res_g_q   <= '0;
			res_b_q   <= '0;
			res_lux_q <= '0;
			acc_q     <= '0;
			if (sts.warm) begin
				if (sts.sat) begin
					res_status_q <= STATUS_WARM_SAT;
					res_cal_q    <= 1'b0;
				end else if (c_q == 16'd0) begin
					res_status_q <= STATUS_WARM_DARK;
					res_cal_q    <= 1'b0;
				end else begin
					res_status_q <= STATUS_WARM_TAKEN;
					res_cal_q    <= cnt_inc >= 7'(WARMUP_COUNT);
				end
			end else begin
				res_cal_q <= 1'b1;
				priority if (sts.sat) begin
					res_status_q <= STATUS_SAT;
				end else if (sts.dark) begin
					res_status_q <= STATUS_TOO_DARK;
				end else begin
					res_status_q <= STATUS_COLOR;
				end
			end
		end
		if (cmd.lux_en) begin
			acc_q <= acc_q + 36'(lux_term);
		end
		if (cmd.lux_store) begin
			res_lux_q <= acc_q[35] ? 21'd0 : acc_q[32:12];
			if (sts.white) begin
				res_r_q <= 8'd255;
				res_g_q <= 8'd255;
				res_b_q <= 8'd255;
			end
		end
		if (cmd.mul1) begin
			xn_q <= XNW'(x_sel) * XNW'(num_q);
		end
		if (cmd.mul2) begin
			cs_q   <= CSW'(c_q) * CSW'(sx_sel);
			zero_q <= sx_sel == 22'd0 || c_q == 16'd0 || span_q == 12'd0;
		end
		if (cmd.mul3) begin
			numer_q <= (NUMW'(xn_q) << 8) - NUMW'(xn_q);
			den_q   <= DENW'(cs_q) * DENW'(span_q);
		end
		if (cmd.div_init) begin
			rem_q <= CMPW'(numer_q);
			sat_q <= CMPW'(numer_q) >= (CMPW'(den_q) << 8);
			d_q   <= CMPW'(den_q) << 7;
			q_q   <= '0;
		end
		if (cmd.div_step) begin
			if (rem_q >= d_q) begin
				rem_q <= rem_q - d_q;
				q_q   <= {q_q[6:0], 1'b1};
			end else begin
				q_q   <= {q_q[6:0], 1'b0};
			end
			d_q <= d_q >> 1;
		end
		if (cmd.store) begin
			unique case (cmd.idx)
				CH_RED:   res_r_q <= ch_val;
				CH_GREEN: res_g_q <= ch_val;
				CH_BLUE:  res_b_q <= ch_val;
				default:  ;
			endcase
		end
		if (cmd.publish) begin
			status     <= res_status_q;
			calibrated <= res_cal_q;
			red_out    <= res_r_q;
			green_out  <= res_g_q;
			blue_out   <= res_b_q;
			lux_q4     <= res_lux_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* src/csc_ctrl.sv */
// controller state machine of the color sensor calibrator
`include "color_sensor_calibrator_defines.svh"

module csc_ctrl import csc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b0000_0000_0001,
		S_PROD1 = 12'b0000_0000_0010,
		S_PROD2 = 12'b0000_0000_0100,
		S_CHECK = 12'b0000_0000_1000,
		S_LUX   = 12'b0000_0001_0000,
		S_LUXW  = 12'b0000_0010_0000,
		S_MUL1  = 12'b0000_0100_0000,
		S_MUL2  = 12'b0000_1000_0000,
		S_MUL3  = 12'b0001_0000_0000,
		S_DIVI  = 12'b0010_0000_0000,
		S_DIVS  = 12'b0100_0000_0000,
		S_STORE = 12'b1000_0000_0000
	} state_t;

	localparam state_t S_FIN_DUMMY = S_IDLE;

	state_t      state_q, state_d;
	logic [1:0]  idx_q, idx_d;
	logic [2:0]  bit_q, bit_d;
	logic        fin_q, fin_d;

	assign in_stall = (state_q != S_IDLE) || fin_q;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		bit_d   = bit_q;
		fin_d   = fin_q;
		cmd     = '0;
		cmd.idx = idx_q;
		if (fin_q) begin
			if (!sts.out_busy) begin
				cmd.publish = 1'b1;
				fin_d       = 1'b0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d  = S_PROD1;
					end
				end
				S_PROD1: begin
					cmd.prod1 = 1'b1;
					state_d   = S_PROD2;
				end
				S_PROD2: begin
					cmd.prod2 = 1'b1;
					state_d   = S_CHECK;
				end
				S_CHECK: begin
					cmd.check = 1'b1;
					idx_d     = CH_RED;
					if (sts.warm || sts.sat || sts.dark) begin
						state_d = S_FIN_DUMMY;
						fin_d   = 1'b1;
					end else begin
						state_d = S_LUX;
					end
				end
				S_LUX: begin
					cmd.lux_en = 1'b1;
					if (idx_q == CH_BLUE) begin
						idx_d   = CH_RED;
						state_d = S_LUXW;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end
				S_LUXW: begin
					cmd.lux_store = 1'b1;
					if (sts.white) begin
						state_d = S_FIN_DUMMY;
						fin_d   = 1'b1;
					end else begin
						state_d = S_MUL1;
					end
				end
				S_MUL1: begin
					cmd.mul1 = 1'b1;
					state_d  = S_MUL2;
				end
				S_MUL2: begin
					cmd.mul2 = 1'b1;
					state_d  = S_MUL3;
				end
				S_MUL3: begin
					cmd.mul3 = 1'b1;
					state_d  = S_DIVI;
				end
				S_DIVI: begin
					cmd.div_init = 1'b1;
					bit_d        = 3'd0;
					state_d      = S_DIVS;
				end
				S_DIVS: begin
					cmd.div_step = 1'b1;
					bit_d        = bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						state_d = S_STORE;
					end
				end
				S_STORE: begin
					cmd.store = 1'b1;
					if (idx_q == CH_BLUE) begin
						state_d = S_FIN_DUMMY;
						fin_d   = 1'b1;
					end else begin
						idx_d   = idx_q + 2'd1;
						state_d = S_MUL1;
					end
				end
				default: state_d = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			bit_q   <= '0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			bit_q   <= bit_d;
			fin_q   <= fin_d;
		end
	end

	`CSC_ASSERT_NEXT(a_accept_starts, !in_stall && in_valid, state_q == S_PROD1)
	`CSC_ASSERT_IMPL(a_store_after_div, state_q == S_STORE, $past(state_q) == S_DIVS && $past(bit_q) == 3'd7)
	`CSC_ASSERT_NEXT(a_publish_frees, cmd.publish, !in_stall)

endmodule

/* src/color_sensor_calibrator.sv */
// top level of the color sensor calibrator: apb registers, controller and datapath
//
// input channel: in_valid/in_stall with clear, red, green, blue raw counts.
// an item is taken when in_valid is high and in_stall is low; one item is
// worked on at a time and in_stall stays high until its result is in the
// output register.
// output channel: out_valid/out_stall with status, calibrated, color and lux.
// the output register holds a result while out_stall is high; a finished
// item then waits in the controller and no new item is taken.
// warmup, saturated and too-dark items are finished at the check step;
// white items after the lux sum; color items run three passes of the
// shared multiply chain and the 8-step restoring divider, one per channel.
// the next item can be taken in the cycle after a result is published.
// apb: white factor at byte address 0, black factor at 4; the user must
// write only while the block is idle; the block itself does not enforce it.
// reset clears the warmup count and sums and restores both factors.
module color_sensor_calibrator import csc_pkg::*; #(
	parameter int WARMUP_COUNT = WARMUP_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] clear_raw,
	input  logic [15:0] red_raw,
	input  logic [15:0] green_raw,
	input  logic [15:0] blue_raw,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic        calibrated,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic [20:0] lux_q4
);

	logic [11:0] wf_q;
	logic [7:0]  bf_q;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? {24'd0, bf_q} : {20'd0, wf_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wf_q <= WHITE_FACTOR_RST;
			bf_q <= BLACK_FACTOR_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2]) begin
				bf_q <= pwdata[7:0];
			end else begin
				wf_q <= pwdata[11:0];
			end
		end
	end

	csc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	csc_datapath #(
		.WARMUP_COUNT (WARMUP_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.clear_raw       (clear_raw),
		.red_raw         (red_raw),
		.green_raw       (green_raw),
		.blue_raw        (blue_raw),
		.white_factor_q8 (wf_q),
		.black_factor_q8 (bf_q),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.status          (status),
		.calibrated      (calibrated),
		.red_out         (red_out),
		.green_out       (green_out),
		.blue_out        (blue_out),
		.lux_q4          (lux_q4)
	);

endmodule
